>>> hw/rtl/dsrs_pkg.sv
package dsrs_pkg;

  localparam int unsigned KeyW  = 16;
  localparam int unsigned IdW   = 6;
  localparam int unsigned RankW = 7;

  localparam logic [RankW-1:0] ListLengthReset = RankW'(10);

  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key;
    logic [IdW-1:0]  id;
  } rec_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic {
    StIdle,
    StEmit
  } state_e;

endpackage

>>> hw/rtl/dsrs_cell.sv
module dsrs_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dsrs_pkg::cell_ctrl_t ctrl_i,
  input  dsrs_pkg::rec_t      new_rec_i,
  input  dsrs_pkg::rec_t      left_rec_i,
  input  logic                left_ins_i,
  input  dsrs_pkg::rec_t      right_rec_i,
  output dsrs_pkg::rec_t      rec_o,
  output logic                ins_o
);

  logic                valid_q, valid_d;
  dsrs_pkg::rec_t      rec_q, rec_d;

  // new record goes ahead of this one only past a strictly smaller key
  assign ins_o = !valid_q || (new_rec_i.key > rec_q.key);

  always_comb begin
    rec_d   = rec_q;
    valid_d = valid_q;
    if (ctrl_i.shift) begin
      rec_d   = right_rec_i;
      valid_d = right_rec_i.valid;
    end else if (ctrl_i.insert && ins_o) begin
      if (left_ins_i) begin
        rec_d   = left_rec_i;
        valid_d = left_rec_i.valid;
      end else begin
        rec_d   = new_rec_i;
        valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  always_comb begin
    rec_o       = rec_q;
    rec_o.valid = valid_q;
  end

endmodule

>>> hw/rtl/descending_stable_rank_sorter_core.sv
// Stable descending sorter built as a chain of MAX_ITEMS insertion cells. A record is
// accepted in every cycle in which start_i is high and busy_o is low; each one is placed
// into sorted position in that same cycle by the cell chain, so loading never waits on
// the sort. A record that arrives with the chain full is dropped. The record flagged
// last_item_i starts emission: the chain shifts toward cell 0, one result per cycle
// until all n records held are out, each marked by result_valid_o for exactly one cycle,
// and the receiver cannot stall them. busy_o is high from the edge that accepts the last
// record until cell 0 gives up the final record; results reach the ports through output
// registers, and the next run may load as soon as busy_o falls, in the cycle that
// carries the final result. Equal counts leave in arrival order. list_length should be
// written via list_length_we_i only while idle (the block does not enforce this) and resets to 10.
module descending_stable_rank_sorter_core #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        list_length_we_i,
  input  logic [dsrs_pkg::RankW-1:0]  list_length_i,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [dsrs_pkg::KeyW-1:0]   volume_i,
  input  logic [dsrs_pkg::IdW-1:0]    item_id_i,
  input  logic                        last_item_i,
  output logic                        result_valid_o,
  output logic [dsrs_pkg::RankW-1:0]  rank_o,
  output logic [dsrs_pkg::IdW-1:0]    out_item_id_o,
  output logic [dsrs_pkg::KeyW-1:0]   out_volume_o,
  output logic                        shown_o,
  output logic                        last_result_o
);

  dsrs_pkg::state_e            state_q, state_d;
  logic [dsrs_pkg::RankW-1:0]  list_len_q;
  logic [dsrs_pkg::RankW-1:0]  rank_q, rank_d;
  logic                        strobe_q, strobe_d;
  logic                        last_q, last_d;
  logic                        shown_q, shown_d;
  logic [dsrs_pkg::RankW-1:0]  orank_q, orank_d;
  logic [dsrs_pkg::IdW-1:0]    oid_q, oid_d;
  logic [dsrs_pkg::KeyW-1:0]   ovol_q, ovol_d;

  dsrs_pkg::rec_t              chain [MAX_ITEMS];
  logic                        ins [MAX_ITEMS];
  dsrs_pkg::rec_t              new_rec;
  dsrs_pkg::rec_t              empty_rec;
  dsrs_pkg::cell_ctrl_t        ctrl;
  logic                        accept;
  logic                        full;

  assign accept = start_i && !busy_o;
  assign full   = chain[MAX_ITEMS-1].valid;
  assign busy_o = (state_q == dsrs_pkg::StEmit);

  always_comb begin
    new_rec.valid = 1'b1;
    new_rec.key   = volume_i;
    new_rec.id    = item_id_i;
    empty_rec     = '0;
  end

  for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
    dsrs_pkg::rec_t left_rec, right_rec;
    logic           left_ins;
    if (g == 0) begin : g_first
      assign left_rec = empty_rec;
      assign left_ins = 1'b0;
    end else begin : g_mid
      assign left_rec = chain[g-1];
      assign left_ins = ins[g-1];
    end
    if (g == MAX_ITEMS-1) begin : g_end
      assign right_rec = empty_rec;
    end else begin : g_inner
      assign right_rec = chain[g+1];
    end
    dsrs_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .new_rec_i  (new_rec),
      .left_rec_i (left_rec),
      .left_ins_i (left_ins),
      .right_rec_i(right_rec),
      .rec_o      (chain[g]),
      .ins_o      (ins[g])
    );
  end

  always_comb begin
    state_d     = state_q;
    rank_d      = rank_q;
    strobe_d    = 1'b0;
    last_d      = 1'b0;
    shown_d     = 1'b0;
    orank_d     = orank_q;
    oid_d       = oid_q;
    ovol_d      = ovol_q;
    ctrl.insert = 1'b0;
    ctrl.shift  = 1'b0;
    unique case (state_q)
      dsrs_pkg::StIdle: begin
        ctrl.insert = accept && !full;
        if (accept && last_item_i) begin
          state_d = dsrs_pkg::StEmit;
          rank_d  = dsrs_pkg::RankW'(1);
        end
      end
      dsrs_pkg::StEmit: begin
        ctrl.shift = 1'b1;
        strobe_d   = 1'b1;
        orank_d    = rank_q;
        oid_d      = chain[0].id;
        ovol_d     = chain[0].key;
        shown_d    = (chain[0].key != '0) && (rank_q <= list_len_q);
        last_d     = !chain[1].valid;
        rank_d     = rank_q + dsrs_pkg::RankW'(1);
        if (!chain[1].valid) begin
          state_d = dsrs_pkg::StIdle;
        end
      end
      default: begin
        state_d = dsrs_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= dsrs_pkg::StIdle;
      list_len_q <= dsrs_pkg::ListLengthReset;
      rank_q     <= '0;
      strobe_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      rank_q   <= rank_d;
      strobe_q <= strobe_d;
      if (list_length_we_i) begin
        list_len_q <= list_length_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    last_q  <= last_d;
    shown_q <= shown_d;
    orank_q <= orank_d;
    oid_q   <= oid_d;
    ovol_q  <= ovol_d;
  end

  assign result_valid_o = strobe_q;
  assign rank_o         = orank_q;
  assign out_item_id_o  = oid_q;
  assign out_volume_o   = ovol_q;
  assign shown_o        = shown_q;
  assign last_result_o  = last_q;

endmodule
